// ===== hdl/lfhd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfhd_pkg
// Shared types and constants of the link flap hold-down timer.
// ----------------------------------------------------------------------------
package lfhd_pkg;

    localparam int TIME_W  = 48;
    localparam int HOLD_W  = 24;
    localparam int KIND_W  = 3;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 56;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [HOLD_W-1:0] INITIAL_HOLD_RST = 24'd1000;
    localparam logic [HOLD_W-1:0] MAX_HOLD_RST     = 24'd60000;
    localparam logic [TIME_W-1:0] TIME_MAX         = {TIME_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        REQ_QUERY      = 3'd0,
        REQ_SET_LINK   = 3'd1,
        REQ_LINK_DOWN  = 3'd2,
        REQ_START_HOLD = 3'd3,
        REQ_CLEAR_HOLD = 3'd4
    } t_req_kind;

    typedef enum logic {
        REG_INITIAL_HOLD = 1'b0,
        REG_MAX_HOLD     = 1'b1
    } t_reg_sel;

    typedef struct packed {
        logic              link_is_up;
        logic [TIME_W-1:0] hold_end_ms;
        logic              hold_pending;
        logic              hold_ended;
        logic              can_use_link;
        logic              changed;
    } t_result;

endpackage
`default_nettype wire

// ===== hdl/link_flap_hold_down_timer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// link_flap_hold_down_timer_top
// Link flap dampening: hold-down timer with exponential backoff per link down.
//
//  channel   dir   handshake              payload
//  s (req)   in    i_s_tvalid/o_s_tready  tdata: now_ms, link_up; tuser: req_type
//  m (resp)  out   o_m_tvalid/i_m_tready  tdata: result flags and hold end time
//  apb       in    psel/penable/pready    initial_hold_ms @0x0, max_hold_ms @0x4
//
//  One request per cycle while o_s_tready is high; its response is registered and shows in the next cycle.
//  The state update and response are computed in the accepting cycle.
//  o_s_tready is high while the response register is empty or being drained.
//  Synchronous active-low reset clears state and loads register defaults.
// ----------------------------------------------------------------------------
module link_flap_hold_down_timer_top
    import lfhd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    output      logic                o_s_tready,
    input  wire logic [S_DATA_W-1:0] i_s_tdata,  // [47:0] now_ms, [48] link_up, rest 0
    input  wire logic [KIND_W-1:0]   i_s_tuser,  // [2:0] req_type
    output      logic                o_m_tvalid,
    input  wire logic                i_m_tready,
    output      logic [M_DATA_W-1:0] o_m_tdata,  // [0] changed, [1] can_use_link,
                                                 // [2] hold_ended, [3] hold_pending,
                                                 // [51:4] hold_end_ms, [52] link_is_up
    input  wire logic                i_psel,
    input  wire logic                i_penable,
    input  wire logic                i_pwrite,
    input  wire logic [APB_AW-1:0]   i_paddr,
    input  wire logic [APB_DW-1:0]   i_pwdata,
    output      logic [APB_DW-1:0]   o_prdata,
    output      logic                o_pready
);

    logic [HOLD_W-1:0] r_initial_hold;
    logic [HOLD_W-1:0] r_max_hold;

    logic              r_up;
    logic              r_seen;
    logic [TIME_W-1:0] r_last;
    logic [HOLD_W-1:0] r_hold;
    logic              r_hold_set;
    logic [TIME_W-1:0] r_hold_until;

    logic              r_out_valid;
    t_result           r_out;

    logic              n_up;
    logic              n_seen;
    logic [TIME_W-1:0] n_last;
    logic [HOLD_W-1:0] n_hold;
    logic              n_hold_set;
    logic [TIME_W-1:0] n_hold_until;
    t_result           n_out;

    logic              accept;
    logic              cfg_wr;
    t_reg_sel          reg_sel;
    t_req_kind         kind;
    logic [TIME_W-1:0] now;
    logic              want_up;
    logic [TIME_W-1:0] elapsed;
    logic              repeat_flap;
    logic [HOLD_W:0]   doubled;
    logic [TIME_W:0]   end_sum;
    logic [TIME_W-1:0] end_sat;
    logic              start_ok;
    logic              old_ended;

    // APB
    assign o_pready = 1'b1;
    assign reg_sel  = t_reg_sel'(i_paddr[2]);
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    always_comb begin
        unique case (reg_sel)
            REG_INITIAL_HOLD: o_prdata = {{(APB_DW-HOLD_W){1'b0}}, r_initial_hold};
            REG_MAX_HOLD:     o_prdata = {{(APB_DW-HOLD_W){1'b0}}, r_max_hold};
            default:          o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_hold <= INITIAL_HOLD_RST;
            r_max_hold     <= MAX_HOLD_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_INITIAL_HOLD: r_initial_hold <= i_pwdata[HOLD_W-1:0];
                REG_MAX_HOLD:     r_max_hold     <= i_pwdata[HOLD_W-1:0];
                default:          r_max_hold     <= r_max_hold;
            endcase
        end
    end

    // request decode
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign kind       = t_req_kind'(i_s_tuser);
    assign now        = i_s_tdata[TIME_W-1:0];
    assign want_up    = i_s_tdata[TIME_W];

    // link down backoff
    assign elapsed     = now - r_last;
    assign repeat_flap = r_seen && ((now < r_last) ||
                         ((elapsed[TIME_W-1:HOLD_W] == '0) &&
                          (elapsed[HOLD_W-1:0] < r_max_hold)));
    assign doubled     = {r_hold, 1'b0};

    // link-up hold end
    assign end_sum   = {1'b0, r_last} + {{(TIME_W-HOLD_W+1){1'b0}}, r_hold};
    assign end_sat   = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];
    assign start_ok  = r_seen && (now < end_sat);
    assign old_ended = r_hold_set && (now >= r_hold_until);

    always_comb begin
        n_up         = r_up;
        n_seen       = r_seen;
        n_last       = r_last;
        n_hold       = r_hold;
        n_hold_set   = r_hold_set;
        n_hold_until = r_hold_until;
        n_out        = '0;
        n_out.hold_ended = old_ended;
        unique case (kind)
            REQ_SET_LINK: begin
                n_up          = want_up;
                n_out.changed = (r_up != want_up);
            end
            REQ_LINK_DOWN: begin
                n_hold_set       = 1'b0;
                n_hold_until     = '0;
                n_last           = now;
                n_seen           = 1'b1;
                n_out.hold_ended = 1'b0;
                if (!repeat_flap) begin
                    n_hold = r_initial_hold;
                end else if (doubled < {1'b0, r_max_hold}) begin
                    n_hold = doubled[HOLD_W-1:0];
                end else begin
                    n_hold = r_max_hold;
                end
            end
            REQ_START_HOLD: begin
                if (start_ok) begin
                    n_hold_set       = 1'b1;
                    n_hold_until     = end_sat;
                    n_out.changed    = 1'b1;
                    n_out.hold_ended = 1'b0;
                end
            end
            REQ_CLEAR_HOLD: begin
                n_hold_set       = 1'b0;
                n_hold_until     = '0;
                n_out.hold_ended = 1'b0;
            end
            default: begin
            end
        endcase
        n_out.link_is_up   = n_up;
        n_out.hold_pending = n_hold_set;
        n_out.hold_end_ms  = n_hold_set ? n_hold_until : '0;
        n_out.can_use_link = n_up && (!n_hold_set || n_out.hold_ended);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up         <= 1'b0;
            r_seen       <= 1'b0;
            r_last       <= '0;
            r_hold       <= '0;
            r_hold_set   <= 1'b0;
            r_hold_until <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_up         <= n_up;
                r_seen       <= n_seen;
                r_last       <= n_last;
                r_hold       <= n_hold;
                r_hold_set   <= n_hold_set;
                r_hold_until <= n_hold_until;
                r_out_valid  <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_DATA_W-$bits(t_result)){1'b0}}, r_out};

endmodule
`default_nettype wire

// ===== hdl/lfhd_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfhd_checker
// Port-level checks of the link flap hold-down timer, bound to the top level.
// ----------------------------------------------------------------------------
module lfhd_checker
    import lfhd_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_s_tvalid,
    input wire logic                o_s_tready,
    input wire logic                o_m_tvalid,
    input wire logic                i_m_tready,
    input wire logic [M_DATA_W-1:0] o_m_tdata
);

    // response stays while stalled
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("response dropped while stalled");

    // every request gives a response in the next cycle
    a_resp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid)
        else $error("request without response");

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[3] |-> (o_m_tdata[51:4] == '0))
        else $error("hold end time set without hold");

    a_ended_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2] |-> o_m_tdata[3])
        else $error("hold ended without hold");

    a_use_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1] |-> o_m_tdata[52] && (!o_m_tdata[3] || o_m_tdata[2]))
        else $error("link usable while down or held");

endmodule

bind link_flap_hold_down_timer_top lfhd_checker u_lfhd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire
